### rtl/lbledge_pkg.sv
`default_nettype none
package lbledge_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF    = 256;
  localparam int unsigned LABEL_WIDTH_DEF  = 8;

  typedef enum logic [1:0] {
    KIND_ADD_VERTEX = 2'd0,
    KIND_ADD_EDGE   = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_REMOVE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_VERTEX_FULL = 2'd1,
    STATUS_EDGE_FULL   = 2'd2,
    STATUS_BAD_VERTEX  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_VERT,
    ST_CMP,
    ST_LAST,
    ST_MOVE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/labeled_edge_table.sv
`default_nettype none
// Labeled graph store: a vertex label table and an edge table of (source, target, label).
// Add vertex and add edge go from accept through the done state to the output register. Query and
// remove walk the stored edges through one compare unit: each edge passes an edge memory read,
// two vertex label reads and a compare; each removal adds a read of the last edge and a write
// of it into the hole. The block takes one item at a time; a finished result sits in the
// output register and the next item is accepted while it waits. Reset empties both tables
// at once.
module labeled_edge_table #(
  parameter int unsigned MAX_VERTICES = lbledge_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = lbledge_pkg::MAX_EDGES_DEF,
  parameter int unsigned LABEL_WIDTH  = lbledge_pkg::LABEL_WIDTH_DEF,
  localparam int unsigned VW   = $clog2(MAX_VERTICES),
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1),
  localparam int unsigned IN_W  = ((4 * LABEL_WIDTH + 2 * VW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((1 + ECW + VW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  // vertex_label, from_vertex, to_vertex, edge_label, from_label, to_label, zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  // kind
  input  wire logic [1:0]       s_tuser,
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  // found, removed_count, new_vertex_index, zero pad
  output      logic [OUT_W-1:0] m_tdata,
  // status
  output      logic [1:0]       m_tuser
);

  localparam int unsigned LW  = LABEL_WIDTH;
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EIW = $clog2(MAX_EDGES);
  localparam int unsigned EW  = 2 * VW + LW;
  localparam int unsigned O_FV = LW;
  localparam int unsigned O_TV = LW + VW;
  localparam int unsigned O_EL = LW + 2 * VW;
  localparam int unsigned O_FL = 2 * LW + 2 * VW;
  localparam int unsigned O_TL = 3 * LW + 2 * VW;

  // input fields
  logic [LW-1:0] in_vlab, in_el, in_fl, in_tl;
  logic [VW-1:0] in_fv, in_tv;
  assign in_vlab = s_tdata[LW-1:0];
  assign in_fv   = s_tdata[O_FV +: VW];
  assign in_tv   = s_tdata[O_TV +: VW];
  assign in_el   = s_tdata[O_EL +: LW];
  assign in_fl   = s_tdata[O_FL +: LW];
  assign in_tl   = s_tdata[O_TL +: LW];

  lbledge_pkg::state_t state, state_next;

  logic [VCW-1:0] vertex_count;
  logic [ECW-1:0] edge_count;
  logic [ECW-1:0] idx;
  logic           is_remove;
  logic [LW-1:0]  q_el, q_fl, q_tl;

  logic                 res_found;
  logic [ECW-1:0]       res_removed;
  logic [VW-1:0]        res_nvi;
  lbledge_pkg::status_t res_status;

  // memories
  logic [LW-1:0] vlabels [MAX_VERTICES];
  logic [EW-1:0] edges   [MAX_EDGES];
  logic [EW-1:0] edge_q;
  logic [LW-1:0] va, vb;

  logic           accept;
  logic           out_free;
  logic           cmp_match;
  logic [ECW-1:0] edge_last;
  logic [EIW-1:0] edge_rd_addr;
  logic           edge_we;
  logic [EIW-1:0] edge_wa;
  logic [EW-1:0]  edge_wd;
  logic           add_v_ok, add_e_ok, bad_vertex;

  assign s_tready  = (state == lbledge_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign edge_last = edge_count - ECW'(1);

  assign bad_vertex = (VCW'(in_fv) >= vertex_count) ||
                      (VCW'(in_tv) >= vertex_count);
  assign add_v_ok   = (vertex_count != VCW'(MAX_VERTICES));
  assign add_e_ok   = !bad_vertex && (edge_count != ECW'(MAX_EDGES));

  // shared compare unit
  assign cmp_match = (edge_q[LW-1:0] == q_el) &&
                     (((va == q_fl) && (vb == q_tl)) || ((va == q_tl) && (vb == q_fl)));

  always_comb begin
    state_next   = state;
    edge_rd_addr = idx[EIW-1:0];
    edge_we      = 1'b0;
    edge_wa      = idx[EIW-1:0];
    edge_wd      = edge_q;
    case (state)
      lbledge_pkg::ST_IDLE: begin
        if (accept) begin
          case (lbledge_pkg::kind_t'(s_tuser))
            lbledge_pkg::KIND_ADD_EDGE: begin
              edge_we    = add_e_ok;
              edge_wa    = edge_count[EIW-1:0];
              edge_wd    = {in_fv, in_tv, in_el};
              state_next = lbledge_pkg::ST_DONE;
            end
            lbledge_pkg::KIND_QUERY, lbledge_pkg::KIND_REMOVE: begin
              state_next = lbledge_pkg::ST_EDGE;
            end
            default: begin
              state_next = lbledge_pkg::ST_DONE;
            end
          endcase
        end
      end
      lbledge_pkg::ST_EDGE: begin
        if (idx >= edge_count) begin
          state_next = lbledge_pkg::ST_DONE;
        end else begin
          state_next = lbledge_pkg::ST_VERT;
        end
      end
      lbledge_pkg::ST_VERT: begin
        state_next = lbledge_pkg::ST_CMP;
      end
      lbledge_pkg::ST_CMP: begin
        if (cmp_match && !is_remove) begin
          state_next = lbledge_pkg::ST_DONE;
        end else if (cmp_match) begin
          state_next = lbledge_pkg::ST_LAST;
        end else begin
          state_next = lbledge_pkg::ST_EDGE;
        end
      end
      lbledge_pkg::ST_LAST: begin
        edge_rd_addr = edge_last[EIW-1:0];
        state_next   = lbledge_pkg::ST_MOVE;
      end
      lbledge_pkg::ST_MOVE: begin
        // last edge fills the hole; same index is checked again
        edge_we    = 1'b1;
        state_next = lbledge_pkg::ST_EDGE;
      end
      lbledge_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lbledge_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbledge_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbledge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edges[edge_wa] <= edge_wd;
    end
    edge_q <= edges[edge_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && (lbledge_pkg::kind_t'(s_tuser) == lbledge_pkg::KIND_ADD_VERTEX) &&
        add_v_ok) begin
      vlabels[vertex_count[VW-1:0]] <= in_vlab;
    end
    va <= vlabels[edge_q[EW-1 -: VW]];
    vb <= vlabels[edge_q[LW +: VW]];
  end

  // counters and results
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      edge_count   <= '0;
    end else begin
      if (accept && (lbledge_pkg::kind_t'(s_tuser) == lbledge_pkg::KIND_ADD_VERTEX) &&
          add_v_ok) begin
        vertex_count <= vertex_count + VCW'(1);
      end
      if (accept && (lbledge_pkg::kind_t'(s_tuser) == lbledge_pkg::KIND_ADD_EDGE) &&
          add_e_ok) begin
        edge_count <= edge_count + ECW'(1);
      end
      if (state == lbledge_pkg::ST_MOVE) begin
        edge_count <= edge_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx         <= '0;
      is_remove   <= (lbledge_pkg::kind_t'(s_tuser) == lbledge_pkg::KIND_REMOVE);
      q_el        <= in_el;
      q_fl        <= in_fl;
      q_tl        <= in_tl;
      res_found   <= 1'b0;
      res_removed <= '0;
      res_nvi     <= '0;
      res_status  <= lbledge_pkg::STATUS_OK;
      case (lbledge_pkg::kind_t'(s_tuser))
        lbledge_pkg::KIND_ADD_VERTEX: begin
          if (add_v_ok) begin
            res_nvi <= vertex_count[VW-1:0];
          end else begin
            res_status <= lbledge_pkg::STATUS_VERTEX_FULL;
          end
        end
        lbledge_pkg::KIND_ADD_EDGE: begin
          if (bad_vertex) begin
            res_status <= lbledge_pkg::STATUS_BAD_VERTEX;
          end else if (!add_e_ok) begin
            res_status <= lbledge_pkg::STATUS_EDGE_FULL;
          end
        end
        default: begin
        end
      endcase
    end else begin
      if ((state == lbledge_pkg::ST_CMP) && cmp_match && !is_remove) begin
        res_found <= 1'b1;
      end
      if ((state == lbledge_pkg::ST_CMP) && !cmp_match) begin
        idx <= idx + ECW'(1);
      end
      if (state == lbledge_pkg::ST_MOVE) begin
        res_removed <= res_removed + ECW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == lbledge_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lbledge_pkg::ST_DONE) && out_free) begin
      m_tdata <= OUT_W'({res_nvi, res_removed, res_found});
      m_tuser <= res_status;
    end
  end

endmodule
`default_nettype wire

### rtl/lbledge_chk.sv
`default_nettype none
module lbledge_chk #(
  parameter int unsigned MAX_VERTICES = lbledge_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = lbledge_pkg::MAX_EDGES_DEF,
  parameter int unsigned LABEL_WIDTH  = lbledge_pkg::LABEL_WIDTH_DEF,
  localparam int unsigned VW   = $clog2(MAX_VERTICES),
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1),
  localparam int unsigned OUT_W = ((1 + ECW + VW + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic [1:0]       m_tuser
);

  logic           o_found;
  logic [ECW-1:0] o_removed;
  logic [VW-1:0]  o_nvi;
  logic           o_status_ok;

  assign o_found     = m_tdata[0];
  assign o_removed   = m_tdata[ECW:1];
  assign o_nvi       = m_tdata[ECW+VW:ECW+1];
  assign o_status_ok = (m_tuser == lbledge_pkg::STATUS_OK);

  // one item in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_found_xor_removed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(o_found && (o_removed != '0)))
    else $error("query and remove results mixed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_status_ok |-> !o_found && (o_removed == '0) && (o_nvi == '0))
    else $error("failed add carries result fields");

  a_nvi_only_add: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_nvi != '0) |-> o_status_ok && !o_found && (o_removed == '0))
    else $error("vertex index on a non add vertex result");

endmodule

bind labeled_edge_table lbledge_chk #(
  .MAX_VERTICES(MAX_VERTICES),
  .MAX_EDGES(MAX_EDGES),
  .LABEL_WIDTH(LABEL_WIDTH)
) u_lbledge_chk (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
`default_nettype wire

### sim/labeled_edge_table_tb.sv
`default_nettype none
module labeled_edge_table_tb;

  typedef lbledge_pkg::kind_t   kind_t;
  typedef lbledge_pkg::status_t status_t;

  localparam kind_t   KIND_ADD_VERTEX    = lbledge_pkg::KIND_ADD_VERTEX;
  localparam kind_t   KIND_ADD_EDGE      = lbledge_pkg::KIND_ADD_EDGE;
  localparam kind_t   KIND_QUERY         = lbledge_pkg::KIND_QUERY;
  localparam kind_t   KIND_REMOVE        = lbledge_pkg::KIND_REMOVE;
  localparam status_t STATUS_OK          = lbledge_pkg::STATUS_OK;
  localparam status_t STATUS_VERTEX_FULL = lbledge_pkg::STATUS_VERTEX_FULL;
  localparam status_t STATUS_EDGE_FULL   = lbledge_pkg::STATUS_EDGE_FULL;
  localparam status_t STATUS_BAD_VERTEX  = lbledge_pkg::STATUS_BAD_VERTEX;

  localparam int MAX_V = 64;
  localparam int MAX_E = 256;

  typedef struct {
    kind_t      kind;
    logic [7:0] vlab;
    logic [5:0] fv;
    logic [5:0] tv;
    logic [7:0] el;
    logic [7:0] fl;
    logic [7:0] tl;
  } item_t;

  typedef struct {
    logic       found;
    logic [8:0] removed;
    logic [5:0] newidx;
    status_t    status;
  } result_t;

  // one directed item; chk set means the result is typed in here
  typedef struct {
    kind_t      kind;
    logic [7:0] vlab;
    logic [5:0] fv;
    logic [5:0] tv;
    logic [7:0] el;
    logic [7:0] fl;
    logic [7:0] tl;
    bit         chk;
    logic       found;
    logic [8:0] removed;
    logic [5:0] newidx;
    status_t    status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // vertex_label, from_vertex, to_vertex, edge_label, from_label, to_label, zero pad
  logic [47:0] s_tdata = '0;
  // kind
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // found, removed_count, new_vertex_index, zero pad
  logic [15:0] m_tdata;
  // status
  logic [1:0]  m_tuser;

  labeled_edge_table dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // graph shadow kept in step with accepted items
  logic [7:0] vert_lab [MAX_V];
  logic [5:0] edge_src [MAX_E];
  logic [5:0] edge_dst [MAX_E];
  logic [7:0] edge_lab [MAX_E];
  int         vert_total = 0;
  int         edge_total = 0;

  result_t awaited_results [$];
  int      errors = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  int tx_gap_pct [4] = '{0, 52, 0, 18};
  int rx_gap_pct [4] = '{0, 0, 52, 18};

  row_t plan [24] = '{
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_REMOVE,     8'hFF, 6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_EDGE,   8'h00, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_BAD_VERTEX},
    '{KIND_ADD_VERTEX, 8'h00, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_VERTEX, 8'hFF, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd1, STATUS_OK},
    '{KIND_ADD_VERTEX, 8'hA5, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd2, STATUS_OK},
    '{KIND_ADD_EDGE,   8'h00, 6'd3, 6'd0,  8'h11, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_BAD_VERTEX},
    '{KIND_ADD_EDGE,   8'h00, 6'd0, 6'd63, 8'h11, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_BAD_VERTEX},
    '{KIND_ADD_EDGE,   8'h00, 6'd0, 6'd1,  8'hFF, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_EDGE,   8'h00, 6'd1, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_EDGE,   8'h00, 6'd2, 6'd2,  8'h5A, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_EDGE,   8'h00, 6'd0, 6'd0,  8'h07, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'hFF, 8'h00, 8'hFF,
      1'b1, 1'b1, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'hFF, 8'hFF, 8'h00,
      1'b1, 1'b1, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h00, 8'h00, 8'hFF,
      1'b1, 1'b1, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'hFF, 8'h00, 8'h00,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h5A, 8'hA5, 8'hA5,
      1'b1, 1'b1, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h07, 8'h00, 8'h00,
      1'b1, 1'b1, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h07, 8'h00, 8'hFF,
      1'b1, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_REMOVE,     8'h00, 6'd0, 6'd0,  8'hFF, 8'hFF, 8'h00,
      1'b1, 1'b0, 9'd1, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'hFF, 8'h00, 8'hFF,
      1'b0, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_REMOVE,     8'h00, 6'd0, 6'd0,  8'h5A, 8'hA5, 8'hA5,
      1'b0, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_ADD_VERTEX, 8'h5A, 6'd0, 6'd0,  8'h00, 8'h00, 8'h00,
      1'b0, 1'b0, 9'd0, 6'd0, STATUS_OK},
    '{KIND_QUERY,      8'h00, 6'd0, 6'd0,  8'h00, 8'hFF, 8'h00,
      1'b0, 1'b0, 9'd0, 6'd0, STATUS_OK}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit edge_joins(input int j, input logic [7:0] el,
                                    input logic [7:0] fl, input logic [7:0] tl);
    logic [7:0] a;
    logic [7:0] b;
    a = vert_lab[edge_src[j]];
    b = vert_lab[edge_dst[j]];
    return edge_lab[j] == el && ((a == fl && b == tl) || (a == tl && b == fl));
  endfunction

  function automatic result_t graph_step(input item_t it);
    result_t r;
    int      j;
    r.found   = 1'b0;
    r.removed = '0;
    r.newidx  = '0;
    r.status  = STATUS_OK;
    case (it.kind)
      KIND_ADD_VERTEX: begin
        if (vert_total >= MAX_V) begin
          r.status = STATUS_VERTEX_FULL;
        end else begin
          vert_lab[vert_total] = it.vlab;
          r.newidx = vert_total[5:0];
          vert_total++;
        end
      end
      KIND_ADD_EDGE: begin
        if (it.fv >= vert_total || it.tv >= vert_total) begin
          r.status = STATUS_BAD_VERTEX;
        end else if (edge_total >= MAX_E) begin
          r.status = STATUS_EDGE_FULL;
        end else begin
          edge_src[edge_total] = it.fv;
          edge_dst[edge_total] = it.tv;
          edge_lab[edge_total] = it.el;
          edge_total++;
        end
      end
      KIND_QUERY: begin
        for (j = 0; j < edge_total; j++) begin
          if (edge_joins(j, it.el, it.fl, it.tl)) r.found = 1'b1;
        end
      end
      default: begin
        // hole is filled from the tail, so the same slot is looked at again
        j = 0;
        while (j < edge_total) begin
          if (edge_joins(j, it.el, it.fl, it.tl)) begin
            edge_src[j] = edge_src[edge_total-1];
            edge_dst[j] = edge_dst[edge_total-1];
            edge_lab[j] = edge_lab[edge_total-1];
            edge_total--;
            r.removed++;
          end else begin
            j++;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] label_pool();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h3C;
      default: return 8'hC3;
    endcase
  endfunction

  // mostly well-formed: valid vertex indices, labels that hit stored edges
  function automatic item_t random_item();
    item_t      it;
    int         pick;
    int         j;
    logic [7:0] a;
    logic [7:0] b;
    it.kind = KIND_QUERY;
    it.vlab = 8'($urandom_range(255));
    it.fv   = 6'($urandom_range(63));
    it.tv   = 6'($urandom_range(63));
    it.el   = 8'($urandom_range(255));
    it.fl   = 8'($urandom_range(255));
    it.tl   = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.kind = KIND_ADD_VERTEX;
      if ($urandom_range(3) != 0) it.vlab = label_pool();
    end else if (pick < 40) begin
      it.kind = KIND_ADD_EDGE;
      if (vert_total > 0 && $urandom_range(9) != 0) begin
        it.fv = 6'($urandom_range(vert_total - 1));
        it.tv = 6'($urandom_range(vert_total - 1));
      end
      if ($urandom_range(3) != 0) it.el = label_pool();
    end else begin
      it.kind = (pick < 70) ? KIND_QUERY : KIND_REMOVE;
      if (edge_total > 0 && $urandom_range(4) != 0) begin
        j = $urandom_range(edge_total - 1);
        a = vert_lab[edge_src[j]];
        b = vert_lab[edge_dst[j]];
        it.el = edge_lab[j];
        if ($urandom_range(1) != 0) begin
          it.fl = a;
          it.tl = b;
        end else begin
          it.fl = b;
          it.tl = a;
        end
        if ($urandom_range(9) == 0) it.tl = label_pool();
      end else if ($urandom_range(1) != 0) begin
        it.el = label_pool();
        it.fl = label_pool();
        it.tl = label_pool();
      end
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.tl, it.fl, it.el, it.tv, it.fv, it.vlab};
    s_tuser  <= it.kind;
    do @(posedge clk); while (!s_tready);
    r = graph_step(it);
    if (typed) r = typed_res;
    awaited_results = {awaited_results, r};
    @(negedge clk);
  endtask

  task automatic wait_empty();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(input logic [15:0] d, input logic [1:0] u);
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing outstanding");
      return;
    end
    want = awaited_results.pop_front();
    if (d[0] !== want.found)
      report_mismatch($sformatf("found %b, want %b", d[0], want.found));
    if (d[9:1] !== want.removed)
      report_mismatch($sformatf("removed_count %0d, want %0d", d[9:1], want.removed));
    if (d[15:10] !== want.newidx)
      report_mismatch($sformatf("new_vertex_index %0d, want %0d", d[15:10], want.newidx));
    if (u !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", u, want.status));
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata, m_tuser);
  end

  initial begin
    item_t   it;
    result_t r;
    int      i;
    int      p;
    int      n;
    r.found   = 1'b0;
    r.removed = '0;
    r.newidx  = '0;
    r.status  = STATUS_OK;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < 24; i++) begin
      it = '{plan[i].kind, plan[i].vlab, plan[i].fv, plan[i].tv,
             plan[i].el, plan[i].fl, plan[i].tl};
      r  = '{plan[i].found, plan[i].removed, plan[i].newidx, plan[i].status};
      send_item(it, plan[i].chk, r);
    end

    for (p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_gap_pct[p];
      rx_stall_pct = rx_gap_pct[p];
      for (n = 0; n < 230; n++) begin
        // long output stall while items keep coming
        if (p == 0 && n == 60) hold_req++;
        if (n == 115) wait_empty();
        send_item(random_item(), 1'b0, r);
      end
      if (p == 1) begin
        // empty the edge table one label combination at a time
        while (edge_total > 0) begin
          it = random_item();
          it.kind = KIND_REMOVE;
          it.el = edge_lab[0];
          it.fl = vert_lab[edge_src[0]];
          it.tl = vert_lab[edge_dst[0]];
          send_item(it, 1'b0, r);
        end
        // fill past capacity with edges between vertex 0 and vertex 1
        for (n = 0; n < MAX_E + 3; n++) begin
          it = random_item();
          it.kind = KIND_ADD_EDGE;
          it.fv = 6'd0;
          it.tv = 6'd1;
          it.el = 8'hC3;
          send_item(it, 1'b0, r);
        end
        it.kind = KIND_QUERY;
        it.el = 8'h3C;
        it.fl = 8'h00;
        it.tl = 8'h00;
        send_item(it, 1'b0, r);
        it.kind = KIND_REMOVE;
        it.el = 8'hC3;
        it.fl = 8'h00;
        it.tl = 8'hFF;
        send_item(it, 1'b1, '{1'b0, 9'd256, 6'd0, STATUS_OK});
      end
    end

    wait_empty();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### labeled_edge_table.f
rtl/lbledge_pkg.sv
rtl/labeled_edge_table.sv
rtl/lbledge_chk.sv
sim/labeled_edge_table_tb.sv
